@@ rtl/lsqe_pkg.sv @@
// shared types and constants of the line segment quad expander
package lsqe_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned MAG_W    = COORD_W;
  localparam int unsigned THICK_W  = 12;
  localparam int unsigned SQ_W     = 2 * MAG_W + 1;
  localparam int unsigned P_W      = THICK_W + MAG_W;
  localparam int unsigned P2_W     = 2 * P_W;
  localparam int unsigned ROOT_W   = 64;
  localparam int unsigned M_W      = THICK_W;
  localparam int unsigned ROOT_STAGES = M_W;
  localparam int unsigned PREP_STAGES = 3;
  localparam int unsigned NUM_STAGES  = PREP_STAGES + ROOT_STAGES + 1;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(16);
  localparam logic [0:0] REG_THICKNESS = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      degen;
    logic                      dx_neg;
    logic                      dy_pos;
  } geom_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [P2_W-1:0] px2;
    logic [P2_W-1:0] py2;
  } prep_t;

endpackage

@@ rtl/lsqe_prep.sv @@
// difference, magnitude, squares and scaled products of a segment
module lsqe_prep (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] sx_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] sy_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] ex_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] ey_i,
  input  logic        [lsqe_pkg::THICK_W-1:0] thick_i,
  output lsqe_pkg::geom_t                     geom_o,
  output lsqe_pkg::prep_t                     prep_o
);
  import lsqe_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy, ndx, ndy;
  logic [MAG_W-1:0]   ax_d, ay_d, ax_q, ay_q;
  logic [THICK_W-1:0] t_q;
  geom_t              g1_d, g1_q, g2_q, g3_q;
  logic [2*MAG_W-1:0] ax2_q, ay2_q;
  logic [P_W-1:0]     px_q, py_q;
  prep_t              p3_q;

  always_comb begin
    dx  = DIFF_W'(ex_i) - DIFF_W'(sx_i);
    dy  = DIFF_W'(ey_i) - DIFF_W'(sy_i);
    ndx = -dx;
    ndy = -dy;
    ax_d = dx[DIFF_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
    ay_d = dy[DIFF_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
    g1_d.sx = sx_i;
    g1_d.sy = sy_i;
    g1_d.ex = ex_i;
    g1_d.ey = ey_i;
    g1_d.degen  = (dx == '0) && (dy == '0);
    g1_d.dx_neg = dx[DIFF_W-1];
    g1_d.dy_pos = !dy[DIFF_W-1] && (dy != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q  <= g1_d;
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      t_q   <= thick_i;
      g2_q  <= g1_q;
      ax2_q <= ax_q * ax_q;
      ay2_q <= ay_q * ay_q;
      px_q  <= P_W'(t_q) * P_W'(ay_q);
      py_q  <= P_W'(t_q) * P_W'(ax_q);
      g3_q  <= g2_q;
      p3_q.sq  <= SQ_W'(ax2_q) + SQ_W'(ay2_q);
      p3_q.px2 <= P2_W'(px_q) * P2_W'(px_q);
      p3_q.py2 <= P2_W'(py_q) * P2_W'(py_q);
    end
  end

  assign geom_o = g3_q;
  assign prep_o = p3_q;

endmodule

@@ rtl/lsqe_root.sv @@
// one result bit a stage: largest m with sq * (2m - 1)^2 <= p^2
module lsqe_root (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [lsqe_pkg::SQ_W-1:0]       sq_i,
  input  logic [lsqe_pkg::P2_W-1:0]       p2_i,
  output logic [lsqe_pkg::M_W-1:0]        m_o
);
  import lsqe_pkg::*;

  // residual r = p^2 - sq*k^2 and s = sq*k for the odd candidate k = 2m - 1
  logic signed [ROOT_W-1:0] r_q [ROOT_STAGES];
  logic signed [ROOT_W-1:0] s_q [ROOT_STAGES];
  logic signed [ROOT_W-1:0] sq_q [ROOT_STAGES];
  logic [M_W-1:0]           m_q [ROOT_STAGES];

  genvar i;
  generate
    for (i = 0; i < ROOT_STAGES; i++) begin : g_stage
      localparam int unsigned J = ROOT_STAGES - 1 - i;
      logic signed [ROOT_W-1:0] r_in, s_in, sq_in, r_try;
      logic [M_W-1:0]           m_in;
      if (i == 0) begin : g_first
        always_comb begin
          sq_in = ROOT_W'(sq_i);
          r_in  = ROOT_W'(p2_i) - sq_in;
          s_in  = -sq_in;
          m_in  = '0;
        end
      end else begin : g_next
        always_comb begin
          sq_in = sq_q[i-1];
          r_in  = r_q[i-1];
          s_in  = s_q[i-1];
          m_in  = m_q[i-1];
        end
      end
      assign r_try = r_in - ((s_in <<< (J + 2)) + (sq_in <<< (2 * J + 2)));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[i] <= sq_in;
          if (!r_try[ROOT_W-1]) begin
            r_q[i] <= r_try;
            s_q[i] <= s_in + (sq_in <<< (J + 1));
            m_q[i] <= m_in | (M_W'(1) << J);
          end else begin
            r_q[i] <= r_in;
            s_q[i] <= s_in;
            m_q[i] <= m_in;
          end
        end
      end
    end
  endgenerate

  assign m_o = m_q[ROOT_STAGES-1];

endmodule

@@ rtl/lsqe_corner.sv @@
// signed offsets, corner sums and saturation, registered as the output stage
module lsqe_corner (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  lsqe_pkg::geom_t                     geom_i,
  input  logic        [lsqe_pkg::M_W-1:0]     mx_i,
  input  logic        [lsqe_pkg::M_W-1:0]     my_i,
  output logic signed [lsqe_pkg::COORD_W-1:0] c0x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c0y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c1x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c1y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c2x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c2y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c3x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] c3y_o,
  output logic                                degen_o
);
  import lsqe_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  function automatic logic [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] maxv, minv;
    maxv = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    minv = -maxv - SUM_W'(1);
    if (v > maxv) return maxv[COORD_W-1:0];
    else if (v < minv) return minv[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] ox, oy, sx, sy, ex, ey;
  logic [8*COORD_W-1:0]    c_d, c_q;
  logic                    degen_q;

  always_comb begin
    ox = geom_i.dy_pos ? -SUM_W'(mx_i) : SUM_W'(mx_i);
    oy = geom_i.dx_neg ? -SUM_W'(my_i) : SUM_W'(my_i);
    sx = SUM_W'(geom_i.sx);
    sy = SUM_W'(geom_i.sy);
    ex = SUM_W'(geom_i.ex);
    ey = SUM_W'(geom_i.ey);
    c_d = {sat(sx + ox), sat(sy + oy), sat(ex + ox), sat(ey + oy),
           sat(ex - ox), sat(ey - oy), sat(sx - ox), sat(sy - oy)};
    // zero-length segment gives an all-zero quad
    if (geom_i.degen) c_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q     <= c_d;
      degen_q <= geom_i.degen;
    end
  end

  assign c0x_o   = c_q[8*COORD_W-1:7*COORD_W];
  assign c0y_o   = c_q[7*COORD_W-1:6*COORD_W];
  assign c1x_o   = c_q[6*COORD_W-1:5*COORD_W];
  assign c1y_o   = c_q[5*COORD_W-1:4*COORD_W];
  assign c2x_o   = c_q[4*COORD_W-1:3*COORD_W];
  assign c2y_o   = c_q[3*COORD_W-1:2*COORD_W];
  assign c3x_o   = c_q[2*COORD_W-1:COORD_W];
  assign c3y_o   = c_q[COORD_W-1:0];
  assign degen_o = degen_q;

endmodule

@@ rtl/line_segment_quad_expander.sv @@
// top level of the line segment quad expander
// Expands a segment into the four corners of a quad of width line_thickness
// (register 0, unsigned Q8.4, reset 1.0). One item is taken every clock
// cycle while the output does not stall. The difference, square and product
// stages come first, then the shift-and-subtract root stages resolve one
// offset bit each, then a last stage adds, saturates and registers the
// corners. A stall on the output freezes the whole pipeline. A zero-length
// segment sets degenerate and gives zero corners.
module line_segment_quad_expander (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsqe_pkg::ADDR_W-1:0]         paddr,
  input  logic [lsqe_pkg::DATA_W-1:0]         pwdata,
  output logic [lsqe_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lsqe_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [lsqe_pkg::COORD_W-1:0] end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner0_x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner0_y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner1_x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner1_y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner2_x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner2_y_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner3_x_o,
  output logic signed [lsqe_pkg::COORD_W-1:0] corner3_y_o,
  output logic                                degenerate_o
);
  import lsqe_pkg::*;

  logic [THICK_W-1:0]    thick_q;
  logic [NUM_STAGES-1:0] v_q;
  logic                  en;
  geom_t                 geom3;
  prep_t                 prep3;
  geom_t                 geom_q [ROOT_STAGES];
  logic [M_W-1:0]        mx, my;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THICKNESS) ? DATA_W'(thick_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= THICK_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_THICKNESS) begin
      thick_q <= pwdata[THICK_W-1:0];
    end
  end

  assign en         = !(v_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = v_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  lsqe_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (en),
    .sx_i    (start_x_i),
    .sy_i    (start_y_i),
    .ex_i    (end_x_i),
    .ey_i    (end_y_i),
    .thick_i (thick_q),
    .geom_o  (geom3),
    .prep_o  (prep3)
  );

  // x offset scales with |dy|, y offset with |dx|
  lsqe_root u_root_x (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (prep3.sq),
    .p2_i  (prep3.px2),
    .m_o   (mx)
  );

  lsqe_root u_root_y (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (prep3.sq),
    .p2_i  (prep3.py2),
    .m_o   (my)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      geom_q[0] <= geom3;
      for (int k = 1; k < ROOT_STAGES; k++) geom_q[k] <= geom_q[k-1];
    end
  end

  lsqe_corner u_corner (
    .clk_i   (clk_i),
    .en_i    (en),
    .geom_i  (geom_q[ROOT_STAGES-1]),
    .mx_i    (mx),
    .my_i    (my),
    .c0x_o   (corner0_x_o),
    .c0y_o   (corner0_y_o),
    .c1x_o   (corner1_x_o),
    .c1y_o   (corner1_y_o),
    .c2x_o   (corner2_x_o),
    .c2y_o   (corner2_y_o),
    .c3x_o   (corner3_x_o),
    .c3y_o   (corner3_y_o),
    .degen_o (degenerate_o)
  );

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (corner0_x_o == '0 && corner3_y_o == '0))
    else $error("degenerate quad with non-zero corners");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during stall");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v_q[0]) |=> v_q[1])
    else $error("item lost between stages");
`endif

endmodule
